>>> rtl/prl_pkg.sv
// Shared types and constants of the positional ring list.
`timescale 1ns / 1ps

package prl_pkg;

  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned OCC_W  = 6;

  typedef enum logic [2:0] {
    CMD_INS_FIRST = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DISPLAY   = 3'd6,
    CMD_COUNT     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT,
    S_PUT,
    S_DROP,
    S_DISP_RD,
    S_DISP_LD,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    setup;
    logic    shift;
    logic    disp_rd;
    logic    put;
    logic    drop;
    logic    emit_resp;
    logic    emit_elem;
    status_t resp_status;
  } prl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t op;
    logic bad_ins;
    logic bad_del;
    logic empty;
    logic full;
    logic no_move;
    logic scan_end;
    logic wb_busy;
    logic out_free;
  } prl_sts_t;

endpackage

>>> rtl/prl_in_if.sv
// Command channel: valid/ready handshake with the command item.
`timescale 1ns / 1ps

interface prl_in_if import prl_pkg::*; ();
  logic               valid;
  logic               ready;
  cmd_t               cmd;
  logic [POS_W-1:0]   position;
  logic [VAL_W-1:0]   value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

>>> rtl/prl_out_if.sv
// Result channel: valid/ready handshake with the result item.
`timescale 1ns / 1ps

interface prl_out_if import prl_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ELEM_W-1:0]  element;
  logic [OCC_W-1:0]   occupancy;
  logic               last_of_run;

  modport source (output valid, status, element, occupancy, last_of_run, input ready);
  modport sink   (input valid, status, element, occupancy, last_of_run, output ready);
endinterface

>>> rtl/prl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/prl_ctrl.sv
// Controller state machine: sequences checks, shifts, display and responses.
`timescale 1ns / 1ps

module prl_ctrl import prl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  prl_sts_t sts,
  output prl_cmd_t cmd
);

  state_t  state_r, state_nxt;
  status_t resp_r, resp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    resp_nxt        = resp_r;
    cmd             = '0;
    cmd.resp_status = resp_r;
    in_ready        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        unique case (sts.op)
          CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
            priority if (sts.bad_ins) begin
              resp_nxt  = ST_BADPOS;
              state_nxt = S_RESP;
            end else if (sts.full) begin
              resp_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.setup = 1'b1;
              state_nxt = sts.no_move ? S_PUT : S_SHIFT;
            end
          end
          CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
            priority if (sts.empty) begin
              resp_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else if (sts.bad_del) begin
              resp_nxt  = ST_BADPOS;
              state_nxt = S_RESP;
            end else begin
              cmd.setup = 1'b1;
              state_nxt = sts.no_move ? S_DROP : S_SHIFT;
            end
          end
          CMD_DISPLAY: begin
            if (sts.empty) begin
              resp_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cmd.setup = 1'b1;
              state_nxt = S_DISP_RD;
            end
          end
          CMD_COUNT: begin
            resp_nxt  = ST_OK;
            state_nxt = S_RESP;
          end
        endcase
      end

      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.scan_end) begin
          unique case (sts.op)
            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: state_nxt = S_PUT;
            default:                                 state_nxt = S_DROP;
          endcase
        end
      end

      S_PUT: begin
        if (!sts.wb_busy) begin
          cmd.put   = 1'b1;
          resp_nxt  = ST_OK;
          state_nxt = S_RESP;
        end
      end

      S_DROP: begin
        if (!sts.wb_busy) begin
          cmd.drop  = 1'b1;
          resp_nxt  = ST_OK;
          state_nxt = S_RESP;
        end
      end

      S_DISP_RD: begin
        if (sts.out_free) begin
          cmd.disp_rd = 1'b1;
          state_nxt   = S_DISP_LD;
        end
      end

      S_DISP_LD: begin
        cmd.emit_elem = 1'b1;
        state_nxt     = sts.scan_end ? S_IDLE : S_DISP_RD;
      end

      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit_resp = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

endmodule

>>> rtl/prl_dp.sv
// Datapath: element store, count, scan pointer, write-back stage and result register.
`timescale 1ns / 1ps

module prl_dp import prl_pkg::*; #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prl_cmd_t          cmd,
  output prl_sts_t          sts,
  input  cmd_t              in_cmd,
  input  logic [POS_W-1:0]  in_position,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              out_ready,
  output logic              out_valid,
  output status_t           out_status,
  output logic [ELEM_W-1:0] out_element,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_last_of_run
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  cmd_t                  op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  wb_valid_r;
  logic [AW-1:0]         wb_addr_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [ELEM_W-1:0]     out_element_r;
  logic [OCC_W-1:0]      out_occupancy_r;
  logic                  out_last_r;

  logic                  is_ins;
  logic [PW-1:0]         pos_w, cnt_w;
  logic [CW-1:0]         idx_c, cnt_m1;
  logic                  scan_end;
  logic                  out_free;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign is_ins = (op_r == CMD_INS_FIRST) || (op_r == CMD_INS_LAST) || (op_r == CMD_INS_AT);
  assign pos_w  = PW'(pos_r);
  assign cnt_w  = PW'(count_r);
  assign cnt_m1 = CW'(count_r - CW'(1));

  always_comb begin
    unique case (op_r)
      CMD_INS_FIRST, CMD_DEL_FIRST: idx_c = '0;
      CMD_INS_LAST:                 idx_c = count_r;
      CMD_DEL_LAST:                 idx_c = cnt_m1;
      CMD_INS_AT, CMD_DEL_AT:       idx_c = CW'(pos_w - PW'(1));
      CMD_DISPLAY, CMD_COUNT:       idx_c = '0;
    endcase
  end

  assign scan_end = is_ins ? (CW'(ptr_r) == idx_r) : (CW'(ptr_r) == cnt_m1);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts          = '0;
    sts.op       = op_r;
    sts.bad_ins  = (op_r == CMD_INS_AT) && ((pos_r == '0) || (pos_w > cnt_w + PW'(1)));
    sts.bad_del  = (op_r == CMD_DEL_AT) && ((pos_r == '0) || (pos_w > cnt_w));
    sts.empty    = (count_r == '0);
    sts.full     = (count_r == CW'(DEPTH));
    sts.no_move  = is_ins ? (idx_c == count_r) : (CW'(idx_c + CW'(1)) == count_r);
    sts.scan_end = scan_end;
    sts.wb_busy  = wb_valid_r;
    sts.out_free = out_free;
  end

  // Pointer: inserts walk down from the tail, deletes and display walk up.
  always_comb begin
    ptr_nxt = ptr_r;
    priority if (cmd.setup) begin
      priority if (is_ins)                 ptr_nxt = AW'(cnt_m1);
      else if (op_r == CMD_DISPLAY)        ptr_nxt = '0;
      else                                 ptr_nxt = AW'(idx_c + CW'(1));
    end else if (cmd.shift) begin
      ptr_nxt = is_ins ? AW'(ptr_r - AW'(1)) : AW'(ptr_r + AW'(1));
    end else if (cmd.emit_elem) begin
      ptr_nxt = AW'(ptr_r + AW'(1));
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.put) begin
      count_nxt = CW'(count_r + CW'(1));
    end else if (cmd.drop) begin
      count_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= CMD_COUNT;
    end else begin
      count_r    <= count_nxt;
      wb_valid_r <= cmd.shift;
      if (cmd.capture) begin
        op_r <= in_cmd;
      end
      if (cmd.emit_resp || cmd.emit_elem) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.capture) begin
      pos_r <= in_position;
      val_r <= DATA_WIDTH'(in_value);
    end
    if (cmd.setup) begin
      idx_r <= idx_c;
    end
    if (cmd.shift) begin
      wb_addr_r <= is_ins ? AW'(ptr_r + AW'(1)) : AW'(ptr_r - AW'(1));
    end
    if (cmd.emit_resp) begin
      out_status_r    <= cmd.resp_status;
      out_element_r   <= '0;
      out_occupancy_r <= OCC_W'(count_r);
      out_last_r      <= 1'b1;
    end else if (cmd.emit_elem) begin
      out_status_r    <= ST_OK;
      out_element_r   <= ELEM_W'(ram_rdata);
      out_occupancy_r <= OCC_W'(count_r);
      out_last_r      <= scan_end;
    end
  end

  // Write-back of a shifted entry takes the port ahead of the new element.
  assign ram_we    = wb_valid_r || cmd.put;
  assign ram_waddr = wb_valid_r ? wb_addr_r : idx_r[AW-1:0];
  assign ram_wdata = wb_valid_r ? ram_rdata : val_r;
  assign ram_re    = cmd.shift || cmd.disp_rd;

  prl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element     = out_element_r;
  assign out_occupancy   = out_occupancy_r;
  assign out_last_of_run = out_last_r;

endmodule

>>> rtl/positional_ring_list_top.sv
// Top level of the positional ring list: controller, datapath and assertions.
`timescale 1ns / 1ps

// Bounded ordered list of up to DEPTH words of DATA_WIDTH bits, held in list
// order in one RAM with one write and one registered read port. One command
// item is taken at a time. Count and any rejected command (bad position,
// empty, full) go from the check straight to the response state. An insert or
// delete moves every entry behind its slot, one entry per cycle through the
// RAM port; the longest move is for an insert at the front of a list one short
// of full or a delete at the front of a full list. Display offers one result
// item per entry, each read from the RAM and then loaded into the result
// register, the last one flagged by last_of_run; an empty list gives a single
// item with status empty. The input side opens again as the final result item
// of a command is loaded. The element field is zero for everything but
// display, and occupancy is the count after the command. A finished result
// waits in an output register, so a stalled result side holds the block only
// once the next result is due.
// No clearing pass follows reset: only slots already written are ever read.
module positional_ring_list_top import prl_pkg::*; #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  prl_in_if.sink     in_ch,
  prl_out_if.source  out_ch
);

  prl_cmd_t dp_cmd;
  prl_sts_t dp_sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  // Sequence each command: capture, check, shift or scan, then respond.
  prl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // Hold the list, its count and the result register.
  prl_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_ch.cmd),
    .in_position     (in_ch.position),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_element     (out_ch.element),
    .out_occupancy   (out_ch.occupancy),
    .out_last_of_run (out_ch.last_of_run)
  );

  // One command at a time: after an accepted item the input side closes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command is still in progress");

  // The new element must never collide with a pending shifted write-back.
  assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.put |-> !dp_sts.wb_busy)
    else $error("element write clashes with write-back");

  // A result is loaded only into a free (or draining) result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.emit_resp || dp_cmd.emit_elem) |-> dp_sts.out_free)
    else $error("result register overwritten before it was taken");

  // Rejected commands carry no element.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |-> (out_ch.element == '0))
    else $error("non-zero element on a rejected command");

endmodule

>>> test/prl_list_checker.sv
// Checker for the positional ring list: tracks the list, predicts and compares results.
`timescale 1ns / 1ps

module prl_list_checker import prl_pkg::*; #(
  parameter int unsigned DEPTH      = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  prl_in_if           in_mon,
  prl_out_if          out_mon,
  output int unsigned mismatches,
  output int unsigned awaited,
  output int unsigned list_len
);

  typedef struct packed {
    status_t           status;
    logic [ELEM_W-1:0] element;
    logic [OCC_W-1:0]  occupancy;
    logic              last_of_run;
  } list_result_t;

  logic [DATA_WIDTH-1:0] held[$];
  list_result_t          due_results[$];
  int unsigned           faults;

  function automatic void queue_result(input status_t st, input logic [ELEM_W-1:0] el,
                                       input logic last);
    list_result_t r;
    r.status      = st;
    r.element     = el;
    r.occupancy   = OCC_W'(held.size());
    r.last_of_run = last;
    due_results.push_back(r);
  endfunction

  // Apply one command to the tracked list and queue the results it gives.
  function automatic void apply_list_command(input cmd_t c, input logic [POS_W-1:0] p,
                                             input logic [VAL_W-1:0] v);
    int unsigned           n;
    int unsigned           slot;
    status_t               st;
    logic [DATA_WIDTH-1:0] word;
    n    = held.size();
    slot = int'(p) - 1;
    st   = ST_OK;
    word = DATA_WIDTH'(v);
    case (c)
      CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
        // position is judged before fullness
        if (c == CMD_INS_AT && (p == 0 || p > n + 1)) st = ST_BADPOS;
        else if (n >= DEPTH) st = ST_FULL;
        else if (c == CMD_INS_FIRST) held.push_front(word);
        else if (c == CMD_INS_LAST) held.push_back(word);
        else held.insert(slot, word);
      end
      CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
        if (n == 0) st = ST_EMPTY;
        else if (c == CMD_DEL_AT && (p == 0 || p > n)) st = ST_BADPOS;
        else if (c == CMD_DEL_FIRST) void'(held.pop_front());
        else if (c == CMD_DEL_LAST) void'(held.pop_back());
        else held.delete(slot);
      end
      default: ;
    endcase
    if (c == CMD_DISPLAY && n != 0) begin
      for (int unsigned i = 0; i < n; i++)
        queue_result(ST_OK, ELEM_W'(held[i]), i + 1 == n);
    end else if (c == CMD_DISPLAY) begin
      queue_result(ST_EMPTY, '0, 1'b1);
    end else begin
      queue_result(st, '0, 1'b1);
    end
  endfunction

  task automatic compare_result();
    list_result_t want;
    if (due_results.size() == 0) begin
      $error("result arrived with nothing expected: status %0d element %0h",
             out_mon.status, out_mon.element);
      faults++;
    end else begin
      want = due_results.pop_front();
      if (out_mon.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_mon.status);
        faults++;
      end
      if (out_mon.element !== want.element) begin
        $error("element: expected %0h, got %0h", want.element, out_mon.element);
        faults++;
      end
      if (out_mon.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, out_mon.occupancy);
        faults++;
      end
      if (out_mon.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_mon.last_of_run);
        faults++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held.delete();
      due_results.delete();
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        apply_list_command(in_mon.cmd, in_mon.position, in_mon.value);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
        compare_result();
    end
    mismatches <= faults;
    awaited    <= due_results.size();
    list_len   <= held.size();
  end

endmodule

>>> test/tb_positional_ring_list_top.sv
// Testbench top of the positional ring list: stimulus, result-side stalls and verdict.
`timescale 1ns / 1ps

module tb_positional_ring_list_top;
  import prl_pkg::*;

  localparam int unsigned LIST_DEPTH     = 32;
  localparam int unsigned LIST_DATA_W    = 32;
  // leave margin after the last result before the verdict
  localparam int unsigned SETTLE_CYCLES  = 2 * LIST_DEPTH + 16;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned TIMEOUT_NS     = 5_000_000;

  typedef enum int unsigned {
    DRIFT_GROW,
    DRIFT_SHRINK,
    DRIFT_MIX
  } drift_t;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned list_len;

  // idle odds in percent, written only by the stimulus process
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        rx_hold_trigger;
  logic        rx_hold_on;

  cmd_t insert_cmds[3]   = '{CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT};
  cmd_t delete_cmds[3]   = '{CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT};
  cmd_t off_grow_cmds[5] = '{CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT, CMD_DISPLAY, CMD_COUNT};
  cmd_t off_drop_cmds[5] = '{CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT, CMD_DISPLAY, CMD_COUNT};

  prl_in_if  in_ch ();
  prl_out_if out_ch ();

  positional_ring_list_top #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (LIST_DATA_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  prl_list_checker #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (LIST_DATA_W)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .awaited    (awaited),
    .list_len   (list_len)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: drop ready at random per the current odds, and hold it low
  // throughout the long stall.
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !rx_hold_on && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long result-side stall, counted here once triggered, so that the list
  // backs up into the output register and the command side stalls.
  initial begin : rx_long_stall
    rx_hold_on = 1'b0;
    wait (rx_hold_trigger === 1'b1);
    @(posedge clk);
    rx_hold_on <= 1'b1;
    for (int unsigned k = 0; k < RX_HOLD_CYCLES; k++) @(posedge clk);
    rx_hold_on <= 1'b0;
  end

  // Offer one command item and hold it until the block takes it. An idle gap,
  // if drawn, goes in front with junk on the payload; valid is only lowered in
  // a step where it is not also raised.
  task automatic offer(input cmd_t c, input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid    <= 1'b0;
      in_ch.cmd      <= cmd_t'($urandom_range(CMD_COUNT));
      in_ch.position <= POS_W'($urandom);
      in_ch.value    <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.position <= p;
    in_ch.value    <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Hold the command side until every predicted result has come out. The first
  // edge lets the checker take in the last accepted item.
  task automatic wait_drained();
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Mostly a position inside 1..span; now and then anything the field allows.
  function automatic logic [POS_W-1:0] pick_position(input int unsigned span);
    if (span == 0 || $urandom_range(9) == 0) return POS_W'($urandom_range(63));
    return POS_W'($urandom_range(span, 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom;
  endfunction

  // One random command, leaning the list towards full, towards empty, or neither.
  task automatic offer_random(input drift_t drift);
    int unsigned       r;
    cmd_t              c;
    logic [POS_W-1:0]  p;
    r = $urandom_range(99);
    case (drift)
      DRIFT_GROW:   c = (r < 70) ? insert_cmds[$urandom_range(2)]
                                 : off_grow_cmds[$urandom_range(4)];
      DRIFT_SHRINK: c = (r < 70) ? delete_cmds[$urandom_range(2)]
                                 : off_drop_cmds[$urandom_range(4)];
      default:      c = cmd_t'($urandom_range(CMD_COUNT));
    endcase
    // list_len may trail by one item; the odd miss only adds a bad position
    if (c == CMD_INS_AT) p = pick_position(list_len + 1);
    else if (c == CMD_DEL_AT) p = pick_position(list_len);
    else p = POS_W'($urandom);
    offer(c, p, pick_value());
  endtask

  // Runs of drifting commands: each run goes on a few items past its goal so
  // that full and empty lists see every command.
  task automatic random_run(input int unsigned target);
    int unsigned sent;
    int unsigned k;
    int unsigned extra;
    int unsigned mix_len;
    bit          at_goal;
    drift_t      drift;
    sent = 0;
    while (sent < target) begin
      drift   = drift_t'($urandom_range(DRIFT_MIX));
      extra   = $urandom_range(8, 3);
      mix_len = $urandom_range(30, 10);
      for (k = 0; sent < target && k < 100 && extra != 0; k++) begin
        offer_random(drift);
        sent++;
        case (drift)
          DRIFT_GROW:   at_goal = list_len >= LIST_DEPTH;
          DRIFT_SHRINK: at_goal = list_len == 0;
          default:      at_goal = k >= mix_len;
        endcase
        if (at_goal) extra--;
      end
    end
  endtask

  // Directed opening: empty-list cases, bad positions at both ends, inserts
  // and deletes at front, back and middle, displays of several sizes.
  task automatic directed_run();
    offer(CMD_DISPLAY,   6'd0,  '0);            // display of an empty list
    offer(CMD_COUNT,     6'd0,  '0);
    offer(CMD_DEL_FIRST, 6'd0,  '0);            // deletes on an empty list
    offer(CMD_DEL_LAST,  6'd0,  '0);
    offer(CMD_DEL_AT,    6'd1,  '0);
    offer(CMD_INS_AT,    6'd0,  32'h1234_5678); // insert position below range
    offer(CMD_INS_AT,    6'd2,  32'h1234_5678); // insert position above count + 1
    offer(CMD_INS_AT,    6'd1,  32'h0000_0000);
    offer(CMD_INS_FIRST, 6'd63, 32'hFFFF_FFFF);
    offer(CMD_INS_LAST,  6'd0,  32'h8000_0001);
    offer(CMD_INS_AT,    6'd4,  32'h5A5A_A5A5); // append through the positional form
    offer(CMD_INS_AT,    6'd63, 32'hDEAD_BEEF);
    offer(CMD_INS_AT,    6'd2,  32'h0000_0001);
    offer(CMD_DISPLAY,   6'd0,  '1);
    offer(CMD_DEL_AT,    6'd0,  '0);            // delete position below range
    offer(CMD_DEL_AT,    6'd63, '0);            // delete position above count
    offer(CMD_DEL_AT,    6'd5,  '0);            // delete the last by position
    offer(CMD_DEL_AT,    6'd2,  '0);
    offer(CMD_DEL_FIRST, 6'd0,  '0);
    offer(CMD_DEL_LAST,  6'd0,  '0);
    offer(CMD_COUNT,     6'd0,  '1);
    offer(CMD_DISPLAY,   6'd0,  '0);
    offer(CMD_DEL_AT,    6'd1,  '0);
    offer(CMD_DISPLAY,   6'd0,  '0);
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_COUNT;
    in_ch.position  = '0;
    in_ch.value     = '0;
    tx_idle_pct     = 29;
    rx_idle_pct     = 56;
    rx_hold_trigger = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // busier commands against a slow result side
    directed_run();
    random_run(170);
    // pause the command side until the list has answered everything
    in_ch.valid <= 1'b0;
    wait_drained();

    // sparser command side against a mostly ready result side
    tx_idle_pct <= 56;
    rx_idle_pct <= 29;
    random_run(170);
    in_ch.valid <= 1'b0;
    wait_drained();

    // no idling at all; open with the long result stall so the block backs up
    tx_idle_pct     <= 0;
    rx_idle_pct     <= 0;
    rx_hold_trigger <= 1'b1;
    random_run(160);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("tb_positional_ring_list_top OK");
    end else begin
      $display("tb_positional_ring_list_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("tb_positional_ring_list_top NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/prl_pkg.sv
rtl/prl_in_if.sv
rtl/prl_out_if.sv
rtl/prl_ram.sv
rtl/prl_ctrl.sv
rtl/prl_dp.sv
rtl/positional_ring_list_top.sv
test/prl_list_checker.sv
test/tb_positional_ring_list_top.sv
